@@ src/hpc_pkg.sv @@
// Package for the half precision converter: modes, constants and conversion functions.
package hpc_pkg;

    typedef enum logic [1:0] {
        MODE_F32_TO_HALF  = 2'd0,
        MODE_HALF_TO_F32  = 2'd1,
        MODE_INT_TO_HALF  = 2'd2,
        MODE_UINT_TO_HALF = 2'd3
    } mode_t;

    localparam logic [15:0] HALF_SIGN = 16'h8000;
    localparam logic [15:0] HALF_INF  = 16'h7c00;
    localparam logic [15:0] HALF_NAN  = 16'h7fff;
    localparam logic [31:0] F32_INF   = 32'h7f800000;
    localparam logic [31:0] F32_QNAN  = 32'h7fc00000;

    // Index of highest set bit of a 16-bit value (0 when zero).
    function automatic logic [3:0] top_bit16(input logic [15:0] x);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (x[i])
            begin
                n = 4'(i);
            end
        end
        return n;
    endfunction

    function automatic logic [15:0] f32_to_half(input logic [31:0] v);
        logic [15:0] sign;
        logic [7:0]  e;
        logic [23:0] m;
        logic [4:0]  sh;
        logic [15:0] r;
        sign = v[31] ? HALF_SIGN : 16'd0;
        e    = v[30:23];
        m    = {1'b1, v[22:0]};
        sh   = 5'(8'd126 - e);
        if (e < 8'd113)
        begin
            if (e >= 8'd103)
            begin
                r = sign | {6'd0, 10'(m >> sh)};
            end
            else
            begin
                r = sign;
            end
        end
        else if (e > 8'd142)
        begin
            if (e == 8'd255 && v[22:0] != 23'd0)
            begin
                r = HALF_NAN;
            end
            else
            begin
                r = sign | HALF_INF;
            end
        end
        else
        begin
            r = sign | {1'b0, 5'(e - 8'd112), v[22:13]};
        end
        return r;
    endfunction

    function automatic logic [31:0] half_to_f32(input logic [15:0] h);
        logic [31:0] sign;
        logic [4:0]  e;
        logic [9:0]  frac;
        logic [3:0]  hb;
        logic [31:0] r;
        sign = {h[15], 31'd0};
        e    = h[14:10];
        frac = h[9:0];
        hb   = top_bit16({6'd0, frac});
        if (e == 5'd0)
        begin
            if (frac == 10'd0)
            begin
                r = sign;
            end
            else
            begin
                r = sign | {1'b0, 8'(hb) + 8'd103,
                            23'(({13'd0, frac} << (5'd23 - 5'(hb))))};
            end
        end
        else if (e == 5'h1f)
        begin
            r = (frac != 10'd0) ? F32_QNAN : (sign | F32_INF);
        end
        else
        begin
            r = sign | {1'b0, 8'(e) + 8'd112, frac, 13'd0};
        end
        return r;
    endfunction

    function automatic logic [15:0] mag_to_half(input logic neg, input logic [31:0] mag);
        logic [3:0]  hb;
        logic [15:0] sh;
        logic [15:0] r;
        hb = top_bit16(mag[15:0]);
        sh = mag[15:0] << (4'd15 - hb);
        if (mag == 32'd0)
        begin
            r = 16'd0;
        end
        else if (mag[31:16] != 16'd0)
        begin
            r = {neg, 15'd0} | HALF_INF;
        end
        else
        begin
            r = {neg, 5'(hb) + 5'd15, sh[14:5]};
        end
        return r;
    endfunction

endpackage

@@ src/hpc_core.sv @@
// Combinational conversion datapath for all four modes.
module hpc_core (
    input  logic [1:0]  mode,
    input  logic [31:0] value,
    output logic [31:0] result
);
    import hpc_pkg::*;

    logic [31:0] mag;

    always_comb
    begin
        mag = value[31] ? (32'd0 - value) : value;
        case (mode_t'(mode))
            MODE_F32_TO_HALF:  result = {16'd0, f32_to_half(value)};
            MODE_HALF_TO_F32:  result = half_to_f32(value[15:0]);
            MODE_INT_TO_HALF:  result = {16'd0, mag_to_half(value[31], mag)};
            MODE_UINT_TO_HALF: result = {16'd0, mag_to_half(1'b0, value)};
            default:           result = 32'd0;
        endcase
    end

endmodule

@@ src/half_precision_converter.sv @@
// Top level of the half precision converter.
// Usage:
//   Slave channel s_axis carries one transaction per operand: tdata holds
//   value (bits 31:0), tuser holds mode (bits 1:0). Master channel m_axis
//   returns one result word per operand in tdata (bits 31:0).
//   Mode 0 float32 to half, 1 half to float32, 2 signed and 3 unsigned
//   integer to half; half results sit in the low 16 bits.
// Pipeline: an input register feeds the conversion logic, which loads the
//   output register.
// Throughput: one transaction per cycle while m_axis_tready is high, set by
//   the single-pass datapath between the two registers.
// Reset: rst_n clears both valid flags; no transactions are in flight.
// Stall: when m_axis_tready is low the output register holds, the input
//   register holds its item if full, and s_axis_tready drops only when
//   both registers are full.
module half_precision_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[31:0]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // result[31:0]
);
    import hpc_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  mode_reg;
    logic [31:0] value_reg;
    logic        out_valid_reg;
    logic [31:0] result_reg;
    logic [31:0] conv;
    logic        out_load;

    hpc_core u_core (
        .mode   (mode_reg),
        .value  (value_reg),
        .result (conv)
    );

    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_load;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            mode_reg  <= s_axis_tuser;
            value_reg <= s_axis_tdata;
        end
        if (out_load && in_valid_reg)
        begin
            result_reg <= conv;
        end
    end

    // hold result while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // never refuse input when pipeline is empty
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("ready low with empty input stage");
    // accepted item moves into output stage next cycle when not stalled
    a_move: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_load |=> out_valid_reg)
        else $error("item lost between stages");

endmodule
